// ===== rtl/csme_pkg.sv =====
// shared types, codes and defaults for the coordinate-list sparse matrix engine
package csme_pkg;

    localparam int SLOTS_DEF      = 4;
    localparam int CAP_DEF        = 64;
    localparam int INDEX_BITS_DEF = 10;

    localparam int ACTION_W = 3;
    localparam int SLOT_W   = 2;
    localparam int IDX_W    = 10;
    localparam int VALUE_W  = 32;

    localparam logic [ACTION_W-1:0] ACT_ASSIGN = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_MULT   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_PRINT  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_NOP    = 3'd5;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic [SLOT_W-1:0]         slot_a;
        logic [SLOT_W-1:0]         slot_b;
        logic [SLOT_W-1:0]         slot_c;
        logic [IDX_W-1:0]          cell_row;
        logic [IDX_W-1:0]          cell_col;
        logic signed [VALUE_W-1:0] cell_value;
    } in_beat_t;

    typedef struct packed {
        logic [IDX_W-1:0]          out_row;
        logic [IDX_W-1:0]          out_col;
        logic signed [VALUE_W-1:0] out_value;
        logic                      last;
        logic                      empty_res;
        logic                      overflow;
    } out_beat_t;

endpackage

// ===== rtl/csme_mul.sv =====
// registered 32 x 32 multiplier keeping the low word of the product
module csme_mul (
    input  logic                         aclk,
    input  logic [csme_pkg::VALUE_W-1:0] mul_a,
    input  logic [csme_pkg::VALUE_W-1:0] mul_b,
    output logic [csme_pkg::VALUE_W-1:0] prod_reg
);

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

endmodule

// ===== rtl/coo_sparse_matrix_engine_unit.sv =====
// top level of the coordinate-list sparse matrix engine with its sequencer and cell memory
//
// Commands arrive on the s_ channel (valid/ready), one beat per command. s_ready is high
// only while the sequencer is idle; every command runs to its end before the next beat
// is taken. Assign and clear finish in the accept cycle. Print reads each cell (PRT_RD,
// then PRT_LD, which waits while an earlier m_ beat is stalled) and sends one m_ beat per
// cell (last flag on the final one), or one empty marker beat for an empty slot. Add
// sorts both operands by insertion, merges them into the target, then compacts the
// target. Mult sorts the operands the same way, visits every operand pair for each
// operand a cell and pushes the nonzero products of matching pairs, then sorts the
// target and folds duplicates. All work goes through one memory port pair (one write,
// one registered read) and one multiplier.
// The result register parts the two sides: a stalled m_ beat holds while new commands
// are accepted, and a later print waits for it to drain.
// Reset (aresetn low, synchronous) empties every slot and clears the overflow flags;
// cell memory contents are not cleared, since only entries below a slot's count are used.
module coo_sparse_matrix_engine_unit #(
    parameter int SLOTS      = csme_pkg::SLOTS_DEF,
    parameter int CAP        = csme_pkg::CAP_DEF,
    parameter int INDEX_BITS = csme_pkg::INDEX_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  csme_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output csme_pkg::out_beat_t m_data
);

    localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IW     = $clog2(CAP);
    localparam int CW     = $clog2(CAP + 1);
    localparam int AW     = SW + IW;
    localparam int DEPTH  = 1 << AW;
    localparam int VW     = csme_pkg::VALUE_W;
    localparam int KW     = 2 * INDEX_BITS;
    localparam int CELL_W = KW + VW;

    typedef enum logic [23:0] {
        IDLE      = 24'h000001,
        SORT_NEXT = 24'h000002,
        SORT_RD   = 24'h000004,
        SORT_LD   = 24'h000008,
        SORT_CHK  = 24'h000010,
        SORT_CMP  = 24'h000020,
        MRG_TOP   = 24'h000040,
        MRG_RB    = 24'h000080,
        MRG_DEC   = 24'h000100,
        CMP_TOP   = 24'h000200,
        CMP_DO    = 24'h000400,
        PRD_TOP   = 24'h000800,
        PRD_LDA   = 24'h001000,
        PRD_JTOP  = 24'h002000,
        PRD_MUL   = 24'h004000,
        PRD_PUSH  = 24'h008000,
        FLD_INIT  = 24'h010000,
        FLD_LD    = 24'h020000,
        FLD_TOP   = 24'h040000,
        FLD_DO    = 24'h080000,
        PRT_RD    = 24'h100000,
        PRT_LD    = 24'h200000,
        PRT_EMPTY = 24'h400000,
        PRT_SPARE = 24'h800000
    } state_t;

    typedef enum logic [1:0] {
        PH_A = 2'd0,
        PH_B = 2'd1,
        PH_C = 2'd2
    } phase_t;

    // cell memory
    logic [CELL_W-1:0] mem [DEPTH];
    logic [AW-1:0]     rd_addr;
    logic [CELL_W-1:0] rd_data_reg;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CELL_W-1:0] wr_data;

    logic [CW-1:0] cnt_reg [SLOTS];
    logic [CW-1:0] cnt_next [SLOTS];
    logic          ovf_reg [SLOTS];
    logic          ovf_next [SLOTS];

    state_t  state_reg, state_next;
    phase_t  ph_reg, ph_next;
    logic [csme_pkg::ACTION_W-1:0] act_reg, act_next;
    logic [SW-1:0] sa_reg, sa_next, sb_reg, sb_next, sc_reg, sc_next, srt_reg, srt_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next, w_reg, w_next;
    logic [CW-1:0] na_reg, na_next, nb_reg, nb_next;
    logic [CELL_W-1:0] ta_reg, ta_next, tb_reg, tb_next;

    logic                m_valid_reg;
    csme_pkg::out_beat_t m_data_reg;
    logic                out_load;
    csme_pkg::out_beat_t out_word;

    logic [SW-1:0]     in_sa, in_sb, in_sc, push_slot;
    logic              in_ok, push_en, push_room, clr_en, cnt_set_en;
    logic [CELL_W-1:0] push_word;
    logic [CW-1:0]     cnt_set_val;
    logic [VW-1:0]     prod;

    function automatic logic [AW-1:0] cell_addr(input logic [SW-1:0] s,
                                                 input logic [CW-1:0] idx);
        return {s, idx[IW-1:0]};
    endfunction

    csme_mul u_mul (
        .aclk     (aclk),
        .mul_a    (ta_reg[VW-1:0]),
        .mul_b    (rd_data_reg[VW-1:0]),
        .prod_reg (prod)
    );

    assign in_sa = SW'(s_data.slot_a);
    assign in_sb = SW'(s_data.slot_b);
    assign in_sc = SW'(s_data.slot_c);
    assign in_ok = (int'(s_data.slot_c) < SLOTS) && (s_data.action <= csme_pkg::ACT_PRINT)
                && ((s_data.action != csme_pkg::ACT_ADD && s_data.action != csme_pkg::ACT_MULT)
                    || (int'(s_data.slot_a) < SLOTS && int'(s_data.slot_b) < SLOTS));

    assign s_ready   = (state_reg == IDLE);
    assign push_slot = (state_reg == IDLE) ? in_sc : sc_reg;
    assign push_room = cnt_reg[push_slot] < CW'(CAP);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // sequencer
    always_comb begin
        state_next  = state_reg;
        ph_next     = ph_reg;
        act_next    = act_reg;
        sa_next     = sa_reg;
        sb_next     = sb_reg;
        sc_next     = sc_reg;
        srt_next    = srt_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        w_next      = w_reg;
        na_next     = na_reg;
        nb_next     = nb_reg;
        ta_next     = ta_reg;
        tb_next     = tb_reg;
        rd_addr     = cell_addr(sc_reg, k_reg);
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        push_en     = 1'b0;
        push_word   = '0;
        clr_en      = 1'b0;
        cnt_set_en  = 1'b0;
        cnt_set_val = '0;
        out_load    = 1'b0;
        out_word    = '0;

        unique case (state_reg)
            IDLE: begin
                if (s_valid && in_ok) begin
                    act_next = s_data.action;
                    sa_next  = in_sa;
                    sb_next  = in_sb;
                    sc_next  = in_sc;
                    unique case (s_data.action)
                        csme_pkg::ACT_ASSIGN: begin
                            push_en   = 1'b1;
                            push_word = {INDEX_BITS'(s_data.cell_row),
                                         INDEX_BITS'(s_data.cell_col), s_data.cell_value};
                        end
                        csme_pkg::ACT_CLEAR: clr_en = 1'b1;
                        csme_pkg::ACT_ADD, csme_pkg::ACT_MULT: begin
                            srt_next   = in_sa;
                            ph_next    = PH_A;
                            i_next     = CW'(1);
                            state_next = SORT_NEXT;
                        end
                        csme_pkg::ACT_PRINT: begin
                            k_next     = '0;
                            state_next = (cnt_reg[in_sc] == '0) ? PRT_EMPTY : PRT_RD;
                        end
                        default: ;
                    endcase
                end
            end
            SORT_NEXT: begin
                if (i_reg >= cnt_reg[srt_reg]) begin
                    unique case (ph_reg)
                        PH_A: begin
                            srt_next = sb_reg;
                            ph_next  = PH_B;
                            i_next   = CW'(1);
                        end
                        PH_B: begin
                            na_next    = cnt_reg[sa_reg];
                            nb_next    = cnt_reg[sb_reg];
                            i_next     = '0;
                            j_next     = '0;
                            state_next = (act_reg == csme_pkg::ACT_ADD) ? MRG_TOP : PRD_TOP;
                        end
                        default: state_next = FLD_INIT;
                    endcase
                end else begin
                    state_next = SORT_RD;
                end
            end
            SORT_RD: begin
                rd_addr    = cell_addr(srt_reg, i_reg);
                state_next = SORT_LD;
            end
            SORT_LD: begin
                ta_next    = rd_data_reg;
                j_next     = i_reg;
                state_next = SORT_CHK;
            end
            SORT_CHK: begin
                if (j_reg == '0) begin
                    wr_en      = 1'b1;
                    wr_addr    = cell_addr(srt_reg, '0);
                    wr_data    = ta_reg;
                    i_next     = i_reg + CW'(1);
                    state_next = SORT_NEXT;
                end else begin
                    rd_addr    = cell_addr(srt_reg, j_reg - CW'(1));
                    state_next = SORT_CMP;
                end
            end
            SORT_CMP: begin
                wr_en   = 1'b1;
                wr_addr = cell_addr(srt_reg, j_reg);
                if (rd_data_reg[CELL_W-1:VW] > ta_reg[CELL_W-1:VW]) begin
                    wr_data    = rd_data_reg;
                    j_next     = j_reg - CW'(1);
                    state_next = SORT_CHK;
                end else begin
                    wr_data    = ta_reg;
                    i_next     = i_reg + CW'(1);
                    state_next = SORT_NEXT;
                end
            end
            MRG_TOP: begin
                if (i_reg >= na_reg && j_reg >= nb_reg) begin
                    k_next     = '0;
                    w_next     = '0;
                    state_next = CMP_TOP;
                end else begin
                    rd_addr    = cell_addr(sa_reg, i_reg);
                    state_next = MRG_RB;
                end
            end
            MRG_RB: begin
                ta_next    = rd_data_reg;
                rd_addr    = cell_addr(sb_reg, j_reg);
                state_next = MRG_DEC;
            end
            MRG_DEC: begin
                push_en = 1'b1;
                if (i_reg < na_reg && j_reg < nb_reg
                    && ta_reg[CELL_W-1:VW] == rd_data_reg[CELL_W-1:VW]) begin
                    push_word = {ta_reg[CELL_W-1:VW], ta_reg[VW-1:0] + rd_data_reg[VW-1:0]};
                    i_next    = i_reg + CW'(1);
                    j_next    = j_reg + CW'(1);
                end else if (i_reg >= na_reg || (j_reg < nb_reg
                             && ta_reg[CELL_W-1:VW] > rd_data_reg[CELL_W-1:VW])) begin
                    push_word = rd_data_reg;
                    j_next    = j_reg + CW'(1);
                end else begin
                    push_word = ta_reg;
                    i_next    = i_reg + CW'(1);
                end
                state_next = MRG_TOP;
            end
            CMP_TOP: begin
                if (k_reg >= cnt_reg[sc_reg]) begin
                    cnt_set_en  = 1'b1;
                    cnt_set_val = w_reg;
                    state_next  = IDLE;
                end else begin
                    rd_addr    = cell_addr(sc_reg, k_reg);
                    state_next = CMP_DO;
                end
            end
            CMP_DO: begin
                // zero cells are dropped, the rest move down
                if (rd_data_reg[VW-1:0] != '0) begin
                    wr_en   = 1'b1;
                    wr_addr = cell_addr(sc_reg, w_reg);
                    wr_data = rd_data_reg;
                    w_next  = w_reg + CW'(1);
                end
                k_next     = k_reg + CW'(1);
                state_next = CMP_TOP;
            end
            PRD_TOP: begin
                if (i_reg >= na_reg) begin
                    srt_next   = sc_reg;
                    ph_next    = PH_C;
                    i_next     = CW'(1);
                    state_next = SORT_NEXT;
                end else begin
                    rd_addr    = cell_addr(sa_reg, i_reg);
                    state_next = PRD_LDA;
                end
            end
            PRD_LDA: begin
                ta_next    = rd_data_reg;
                j_next     = '0;
                state_next = PRD_JTOP;
            end
            PRD_JTOP: begin
                if (j_reg >= nb_reg) begin
                    i_next     = i_reg + CW'(1);
                    state_next = PRD_TOP;
                end else begin
                    rd_addr    = cell_addr(sb_reg, j_reg);
                    state_next = PRD_MUL;
                end
            end
            PRD_MUL: begin
                tb_next    = rd_data_reg;
                state_next = PRD_PUSH;
            end
            PRD_PUSH: begin
                if (ta_reg[KW/2+VW-1:VW] == tb_reg[CELL_W-1:KW/2+VW] && prod != '0) begin
                    push_en   = 1'b1;
                    push_word = {ta_reg[CELL_W-1:KW/2+VW], tb_reg[KW/2+VW-1:VW], prod};
                end
                j_next     = j_reg + CW'(1);
                state_next = PRD_JTOP;
            end
            FLD_INIT: begin
                if (cnt_reg[sc_reg] == '0) begin
                    state_next = IDLE;
                end else begin
                    rd_addr    = cell_addr(sc_reg, '0);
                    state_next = FLD_LD;
                end
            end
            FLD_LD: begin
                ta_next    = rd_data_reg;
                k_next     = CW'(1);
                w_next     = '0;
                state_next = FLD_TOP;
            end
            FLD_TOP: begin
                if (k_reg >= cnt_reg[sc_reg]) begin
                    wr_en       = 1'b1;
                    wr_addr     = cell_addr(sc_reg, w_reg);
                    wr_data     = ta_reg;
                    cnt_set_en  = 1'b1;
                    cnt_set_val = w_reg + CW'(1);
                    state_next  = IDLE;
                end else begin
                    rd_addr    = cell_addr(sc_reg, k_reg);
                    state_next = FLD_DO;
                end
            end
            FLD_DO: begin
                // target is sorted, so duplicates sit next to each other
                if (rd_data_reg[CELL_W-1:VW] == ta_reg[CELL_W-1:VW]) begin
                    ta_next = {ta_reg[CELL_W-1:VW], ta_reg[VW-1:0] + rd_data_reg[VW-1:0]};
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = cell_addr(sc_reg, w_reg);
                    wr_data = ta_reg;
                    w_next  = w_reg + CW'(1);
                    ta_next = rd_data_reg;
                end
                k_next     = k_reg + CW'(1);
                state_next = FLD_TOP;
            end
            PRT_RD: begin
                rd_addr    = cell_addr(sc_reg, k_reg);
                state_next = PRT_LD;
            end
            PRT_LD: begin
                // hold the read address so the data stays while the beat waits
                rd_addr = cell_addr(sc_reg, k_reg);
                if (!m_valid_reg || m_ready) begin
                    out_load           = 1'b1;
                    out_word.out_row   = csme_pkg::IDX_W'(rd_data_reg[CELL_W-1:KW/2+VW]);
                    out_word.out_col   = csme_pkg::IDX_W'(rd_data_reg[KW/2+VW-1:VW]);
                    out_word.out_value = rd_data_reg[VW-1:0];
                    out_word.last      = (k_reg + CW'(1) == cnt_reg[sc_reg]);
                    out_word.empty_res = 1'b0;
                    out_word.overflow  = ovf_reg[sc_reg];
                    k_next             = k_reg + CW'(1);
                    state_next         = out_word.last ? IDLE : PRT_RD;
                end
            end
            PRT_EMPTY: begin
                if (!m_valid_reg || m_ready) begin
                    out_load           = 1'b1;
                    out_word.last      = 1'b1;
                    out_word.empty_res = 1'b1;
                    out_word.overflow  = ovf_reg[sc_reg];
                    state_next         = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase

        if (push_en && push_room) begin
            wr_en   = 1'b1;
            wr_addr = cell_addr(push_slot, cnt_reg[push_slot]);
            wr_data = push_word;
        end
    end

    // slot counts and overflow flags
    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            cnt_next[s] = cnt_reg[s];
            ovf_next[s] = ovf_reg[s];
        end
        if (clr_en) begin
            cnt_next[in_sc] = '0;
            ovf_next[in_sc] = 1'b0;
        end
        if (cnt_set_en) begin
            cnt_next[sc_reg] = cnt_set_val;
        end
        if (push_en) begin
            if (push_room) begin
                cnt_next[push_slot] = cnt_reg[push_slot] + CW'(1);
            end else begin
                ovf_next[push_slot] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            ph_reg      <= PH_A;
            sc_reg      <= '0;
            m_valid_reg <= 1'b0;
            for (int s = 0; s < SLOTS; s++) begin
                cnt_reg[s] <= '0;
                ovf_reg[s] <= 1'b0;
            end
        end else begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            sc_reg    <= sc_next;
            for (int s = 0; s < SLOTS; s++) begin
                cnt_reg[s] <= cnt_next[s];
                ovf_reg[s] <= ovf_next[s];
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        act_reg <= act_next;
        sa_reg  <= sa_next;
        sb_reg  <= sb_next;
        srt_reg <= srt_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        k_reg   <= k_next;
        w_reg   <= w_next;
        na_reg  <= na_next;
        nb_reg  <= nb_next;
        ta_reg  <= ta_next;
        tb_reg  <= tb_next;
        if (out_load) begin
            m_data_reg <= out_word;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg[sc_reg] <= CW'(CAP))
        else $error("slot count above capacity");

    a_wr_in_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (int'(wr_addr[IW-1:0]) < CAP))
        else $error("cell write beyond slot capacity");

    a_print_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == PRT_LD) |-> (k_reg < cnt_reg[sc_reg]))
        else $error("print reads past slot count");

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the coordinate-list sparse matrix engine
`timescale 1ns / 1ps

module tb_top;

    localparam int NSLOT = csme_pkg::SLOTS_DEF;
    localparam int NCAP = csme_pkg::CAP_DEF;
    localparam int ITEM_GOAL = 140;
    localparam longint CYCLE_LIMIT = 8000000;

    typedef struct {
        logic [csme_pkg::IDX_W-1:0]   r;
        logic [csme_pkg::IDX_W-1:0]   c;
        logic [csme_pkg::VALUE_W-1:0] v;
    } cell_t;

    typedef struct {
        csme_pkg::in_beat_t beat;
        bit                 drain;
    } cmd_t;

    logic                aclk = 0;
    logic                aresetn = 0;
    logic                s_valid = 0;
    logic                s_ready;
    csme_pkg::in_beat_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 0;
    csme_pkg::out_beat_t m_data;

    cmd_t                cmd_q[$];
    csme_pkg::out_beat_t printed_q[$];
    cell_t     mat[NSLOT][NCAP];
    cell_t     opa[NCAP];
    cell_t     opb[NCAP];
    int        mat_cnt[NSLOT];
    bit        mat_ovf[NSLOT];
    int        errors = 0;
    int        beats_seen = 0;
    int        cmds_done = 0;
    longint    cyc = 0;

    coo_sparse_matrix_engine_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    function automatic int key_cmp(cell_t x, cell_t y);
        if (x.r != y.r) return x.r > y.r ? 1 : -1;
        if (x.c != y.c) return x.c > y.c ? 1 : -1;
        return 0;
    endfunction

    task automatic push_cell(int s, logic [csme_pkg::IDX_W-1:0] r,
                             logic [csme_pkg::IDX_W-1:0] c,
                             logic [csme_pkg::VALUE_W-1:0] v);
        if (mat_cnt[s] < NCAP) begin
            mat[s][mat_cnt[s]] = '{r, c, v};
            mat_cnt[s]++;
        end else begin
            mat_ovf[s] = 1'b1;
        end
    endtask

    // stable insertion sort by (row, col)
    task automatic sort_matrix(int s);
        cell_t t;
        int j;
        for (int i = 1; i < mat_cnt[s]; i++) begin
            t = mat[s][i];
            j = i;
            while (j > 0 && key_cmp(mat[s][j-1], t) > 0) begin
                mat[s][j] = mat[s][j-1];
                j--;
            end
            mat[s][j] = t;
        end
    endtask

    task automatic sort_operands(int sa, int sb, output int na, output int nb);
        sort_matrix(sa);
        sort_matrix(sb);
        na = mat_cnt[sa];
        nb = mat_cnt[sb];
        for (int i = 0; i < na; i++) opa[i] = mat[sa][i];
        for (int i = 0; i < nb; i++) opb[i] = mat[sb][i];
    endtask

    task automatic add_matrices(int sa, int sb, int sc);
        int na, nb, i, j, w, cmp;
        sort_operands(sa, sb, na, nb);
        i = 0;
        j = 0;
        w = 0;
        while (i < na || j < nb) begin
            if (i >= na) cmp = 1;
            else if (j >= nb) cmp = -1;
            else cmp = key_cmp(opa[i], opb[j]);
            if (cmp == 0) begin
                push_cell(sc, opa[i].r, opa[i].c, opa[i].v + opb[j].v);
                i++;
                j++;
            end else if (cmp > 0) begin
                push_cell(sc, opb[j].r, opb[j].c, opb[j].v);
                j++;
            end else begin
                push_cell(sc, opa[i].r, opa[i].c, opa[i].v);
                i++;
            end
        end
        // zero cells vanish from the whole target, old ones too
        for (int k = 0; k < mat_cnt[sc]; k++) begin
            if (mat[sc][k].v != 0) begin
                mat[sc][w] = mat[sc][k];
                w++;
            end
        end
        mat_cnt[sc] = w;
    endtask

    task automatic mult_matrices(int sa, int sb, int sc);
        int na, nb, j;
        logic [csme_pkg::VALUE_W-1:0] p;
        sort_operands(sa, sb, na, nb);
        for (int i = 0; i < na; i++)
            for (int k = 0; k < nb; k++) begin
                p = opa[i].v * opb[k].v;
                if (opa[i].c == opb[k].r && p != 0) push_cell(sc, opa[i].r, opb[k].c, p);
            end
        // fold duplicates into the first occurrence, a zero sum stays
        for (int i = 0; i < mat_cnt[sc]; i++) begin
            j = i + 1;
            while (j < mat_cnt[sc]) begin
                if (key_cmp(mat[sc][i], mat[sc][j]) == 0) begin
                    mat[sc][i].v += mat[sc][j].v;
                    for (int m = j; m < mat_cnt[sc] - 1; m++) mat[sc][m] = mat[sc][m+1];
                    mat_cnt[sc]--;
                end else begin
                    j++;
                end
            end
        end
        sort_matrix(sc);
    endtask

    task automatic apply_command(csme_pkg::in_beat_t b);
        csme_pkg::out_beat_t e;
        int sc;
        sc = b.slot_c;
        case (b.action)
            csme_pkg::ACT_ASSIGN: push_cell(sc, b.cell_row, b.cell_col, b.cell_value);
            csme_pkg::ACT_CLEAR: begin
                mat_cnt[sc] = 0;
                mat_ovf[sc] = 1'b0;
            end
            csme_pkg::ACT_ADD: add_matrices(b.slot_a, b.slot_b, sc);
            csme_pkg::ACT_MULT: mult_matrices(b.slot_a, b.slot_b, sc);
            csme_pkg::ACT_PRINT: begin
                if (mat_cnt[sc] == 0) begin
                    e = '0;
                    e.last = 1'b1;
                    e.empty_res = 1'b1;
                    e.overflow = mat_ovf[sc];
                    printed_q = {printed_q, e};
                end
                for (int k = 0; k < mat_cnt[sc]; k++) begin
                    e.out_row = mat[sc][k].r;
                    e.out_col = mat[sc][k].c;
                    e.out_value = mat[sc][k].v;
                    e.last = (k == mat_cnt[sc] - 1);
                    e.empty_res = 1'b0;
                    e.overflow = mat_ovf[sc];
                    printed_q = {printed_q, e};
                end
            end
            default: ;
        endcase
    endtask

    // command driver
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_command(s_data);
                void'(cmd_q.pop_front());
                cmds_done++;
            end
            if (!(s_valid && !s_ready)) begin
                if (cmd_q.size() > 0 && cmd_q[0].drain && printed_q.size() == 0)
                    void'(cmd_q.pop_front());
                if (cmd_q.size() > 0 && !cmd_q[0].drain &&
                    ((cmds_done >= 60 && cmds_done < 100) || $urandom_range(0, 99) >= 18)) begin
                    s_valid <= 1'b1;
                    s_data <= cmd_q[0].beat;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                beats_seen++;
                if (printed_q.size() == 0) begin
                    $display("%0t: unexpected beat %p", $time, m_data);
                    errors++;
                end else if (m_data !== printed_q[0]) begin
                    $display("%0t: mismatch expected %p actual %p", $time, printed_q[0], m_data);
                    errors++;
                    void'(printed_q.pop_front());
                end else begin
                    void'(printed_q.pop_front());
                end
            end
            m_ready <= (beats_seen >= 40 && beats_seen < 120) || $urandom_range(0, 99) >= 18;
        end
    end

    always @(posedge aclk) begin
        if (cyc >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    int n_items = 0;

    task automatic put(logic [csme_pkg::ACTION_W-1:0] act, int sa, int sb, int sc,
                       int r = 0, int c = 0, logic [csme_pkg::VALUE_W-1:0] v = 0);
        cmd_t t;
        t.drain = 1'b0;
        t.beat.action = act;
        t.beat.slot_a = csme_pkg::SLOT_W'(sa);
        t.beat.slot_b = csme_pkg::SLOT_W'(sb);
        t.beat.slot_c = csme_pkg::SLOT_W'(sc);
        t.beat.cell_row = csme_pkg::IDX_W'(r);
        t.beat.cell_col = csme_pkg::IDX_W'(c);
        t.beat.cell_value = v;
        cmd_q = {cmd_q, t};
        n_items++;
    endtask

    task automatic hold_until_drained();
        cmd_t t;
        t.drain = 1'b1;
        t.beat = '0;
        cmd_q = {cmd_q, t};
    endtask

    function automatic int rnd_idx();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 3);
    endfunction

    function automatic logic [csme_pkg::VALUE_W-1:0] rnd_val();
        case ($urandom_range(0, 6))
            0: return 0;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            4: return $urandom;
            default: return $urandom_range(1, 9) * ($urandom_range(0, 1) ? 1 : -1);
        endcase
    endfunction

    task automatic fill_slot(int s, int n);
        put(csme_pkg::ACT_CLEAR, rnd_idx() & 3, $urandom_range(0, 3), s);
        for (int i = 0; i < n; i++) put(csme_pkg::ACT_ASSIGN, $urandom_range(0, 3),
                                        $urandom_range(0, 3), s, rnd_idx(), rnd_idx(),
                                        rnd_val());
    endtask

    initial begin
        for (int s = 0; s < NSLOT; s++) begin
            mat_cnt[s] = 0;
            mat_ovf[s] = 1'b0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every action, empty print, shared slots
        put(csme_pkg::ACT_PRINT, 0, 0, 3);
        put(csme_pkg::ACT_ASSIGN, 0, 0, 0, 1023, 1023, 32'h7fff_ffff);
        put(csme_pkg::ACT_ASSIGN, 3, 3, 0, 0, 0, 32'h8000_0000);
        put(csme_pkg::ACT_ASSIGN, 0, 0, 0, 1023, 0, 32'hffff_ffff);
        put(csme_pkg::ACT_ASSIGN, 0, 0, 1, 0, 0, 32'h8000_0000);
        put(csme_pkg::ACT_ASSIGN, 0, 0, 1, 1023, 1023, 1);
        put(csme_pkg::ACT_ASSIGN, 0, 0, 1, 0, 1023, 5);
        put(csme_pkg::ACT_PRINT, 0, 0, 0);
        put(csme_pkg::ACT_ADD, 0, 1, 2);
        put(csme_pkg::ACT_PRINT, 0, 0, 2);
        put(csme_pkg::ACT_MULT, 0, 1, 3);
        put(csme_pkg::ACT_PRINT, 0, 0, 3);
        put(csme_pkg::ACT_NOP, 1, 2, 3, 5, 5, 5);
        put(3'd6, 0, 0, 0);
        put(3'd7, 3, 3, 3, 1023, 1023, 32'hffff_ffff);
        put(csme_pkg::ACT_ADD, 1, 1, 1);
        put(csme_pkg::ACT_MULT, 2, 2, 2);
        put(csme_pkg::ACT_PRINT, 0, 0, 1);
        put(csme_pkg::ACT_PRINT, 0, 0, 2);
        put(csme_pkg::ACT_CLEAR, 0, 0, 0);
        put(csme_pkg::ACT_PRINT, 0, 0, 0);
        hold_until_drained();

        // overflow through a mult with 72 products
        fill_slot(0, 0);
        fill_slot(1, 0);
        fill_slot(2, 0);
        for (int i = 0; i < 9; i++) put(csme_pkg::ACT_ASSIGN, 0, 0, 0, i, 0, i + 2);
        for (int j = 0; j < 8; j++) put(csme_pkg::ACT_ASSIGN, 0, 0, 1, 0, j, 3);
        put(csme_pkg::ACT_MULT, 0, 1, 2);
        put(csme_pkg::ACT_ASSIGN, 0, 0, 2, 7, 7, 7);
        put(csme_pkg::ACT_PRINT, 0, 0, 2);
        put(csme_pkg::ACT_CLEAR, 0, 0, 2);
        put(csme_pkg::ACT_PRINT, 0, 0, 2);

        while (n_items < ITEM_GOAL) begin
            case ($urandom_range(0, 9))
                0: put(csme_pkg::ACTION_W'($urandom_range(0, 7)), $urandom_range(0, 3),
                       $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 1023),
                       $urandom_range(0, 1023), $urandom);
                1: hold_until_drained();
                default: begin
                    int sa, sb, sc;
                    sa = $urandom_range(0, 3);
                    sb = $urandom_range(0, 3);
                    sc = $urandom_range(0, 3);
                    fill_slot(sa, $urandom_range(0, 5));
                    if (sb != sa) fill_slot(sb, $urandom_range(0, 5));
                    if ($urandom_range(0, 2) == 0 && sc != sa && sc != sb)
                        fill_slot(sc, $urandom_range(0, 3));
                    put($urandom_range(0, 1) ? csme_pkg::ACT_ADD : csme_pkg::ACT_MULT,
                        sa, sb, sc);
                    put(csme_pkg::ACT_PRINT, 0, 0, sc);
                    if ($urandom_range(0, 1)) put(csme_pkg::ACT_PRINT, 0, 0, sa);
                end
            endcase
        end

        wait (cmd_q.size() == 0 && !s_valid);
        wait (printed_q.size() == 0);
        repeat (300) @(posedge aclk);
        if (errors == 0 && printed_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/csme_pkg.sv
rtl/csme_mul.sv
rtl/coo_sparse_matrix_engine_unit.sv
tb/sv/tb_top.sv
